>>> design/bfe_pkg.sv
package bfe_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 4;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned RunIdxW = 3;

  localparam logic [CharW-1:0] ChNul     = 8'h00;
  localparam logic [CharW-1:0] ChPercent = 8'h25;
  localparam logic [CharW-1:0] ChBang    = 8'h21;
  localparam logic [CharW-1:0] ChMinus   = 8'h2D;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChOne     = 8'h31;
  localparam logic [CharW-1:0] ChLowD    = 8'h64;
  localparam logic [CharW-1:0] ChLowU    = 8'h75;
  localparam logic [CharW-1:0] ChLowB    = 8'h62;
  localparam logic [CharW-1:0] ChLowC    = 8'h63;

  // Kind of run the back end has to emit for one queued command.
  typedef enum logic [1:0] {
    OP_LIT  = 2'd0,  // one character
    OP_SDEC = 2'd1,  // sign character, then three digits
    OP_UDEC = 2'd2,  // three digits
    OP_BIN  = 2'd3   // eight bits, MSB first
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [CharW-1:0]  ch;   // literal, sign character, or value for binary
    logic [DigitW-1:0] d2;   // hundreds
    logic [DigitW-1:0] d1;   // tens
    logic [DigitW-1:0] d0;   // ones
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> design/byte_format_expander.sv
// Format expander: one format-string character per input transfer, with an
// 8-bit value for conversions; emits the expanded characters one per output
// transfer. out_last_of_run marks the final character caused by an input.
//   input : in_valid/in_ready, in_fmt_char, in_value
//   output: out_valid/out_ready, out_char, out_last_of_run
// '%' arms an escape and emits nothing; NUL ends a string and emits nothing.
// Conversions: d (sign + 3 digits), u (3 digits), b (8 bits), c, %, else '!'.
// Structure: front end classifies and turns the value into decimal digits,
// a 4-entry command queue decouples it from the back end, which walks each
// command's run and drives a registered output stage.
// An input's first character passes through the queue, then the output register.
// Throughput: one character per cycle while out_ready is high, bounded by
// the back end output register; plain characters then sustain one input
// per cycle; an expansion of N characters (N = 1, 3, 4 or 8) holds the
// back end for its run, the queue taking inputs until it holds four commands.
// A stalled receiver holds the output register; in_ready drops only when
// the queue is full. Synchronous reset empties the queue, clears the output
// valid and the escape flag.
module byte_format_expander (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bfe_pkg::CharW-1:0] in_fmt_char,
  input  logic [bfe_pkg::CharW-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bfe_pkg::CharW-1:0] out_char,
  output logic                      out_last_of_run
);

  bfe_pkg::q_status_t q_status;
  bfe_pkg::cmd_t      push_cmd;
  bfe_pkg::cmd_t      head;
  logic               push;
  logic               pop;

  bfe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_fmt_char (in_fmt_char),
    .in_value    (in_value),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  bfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  bfe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> design/bfe_front.sv
module bfe_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bfe_pkg::CharW-1:0]  in_fmt_char,
  input  logic [bfe_pkg::CharW-1:0]  in_value,
  input  bfe_pkg::q_status_t         q_status,
  output logic                       push,
  output bfe_pkg::cmd_t              push_cmd
);

  logic                      esc_r;
  logic                      esc_nxt;
  logic                      xfer;
  logic                      emit;
  logic [bfe_pkg::CharW-1:0] mag;
  logic [1:0]                hund;
  logic [6:0]                rest;
  logic [14:0]               tens_prod;
  logic [3:0]                tens;
  logic [6:0]                tens_x10;
  logic [6:0]                ones;
  bfe_pkg::cmd_t             cmd;

  assign in_ready = !q_status.full;
  assign xfer     = in_valid && in_ready;

  // Decimal digits of the magnitude; two's complement for signed form.
  always_comb begin
    if (in_fmt_char == bfe_pkg::ChLowD && in_value[7]) begin
      mag = ~in_value + 8'd1;
    end else begin
      mag = in_value;
    end
    if (mag >= 8'd200) begin
      hund = 2'd2;
      rest = 7'(mag - 8'd200);
    end else if (mag >= 8'd100) begin
      hund = 2'd1;
      rest = 7'(mag - 8'd100);
    end else begin
      hund = 2'd0;
      rest = mag[6:0];
    end
    // x/10 == (x*205)>>11 for x < 100
    tens_prod = 15'(rest) * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = 7'({3'd0, tens} * 7'd10);
    ones      = rest - tens_x10;
  end

  always_comb begin
    esc_nxt  = esc_r;
    emit     = 1'b0;
    cmd.op   = bfe_pkg::OP_LIT;
    cmd.ch   = in_fmt_char;
    cmd.d2   = {2'd0, hund};
    cmd.d1   = tens;
    cmd.d0   = ones[3:0];
    if (!esc_r) begin
      if (in_fmt_char == bfe_pkg::ChPercent) begin
        esc_nxt = 1'b1;
      end else if (in_fmt_char != bfe_pkg::ChNul) begin
        emit = 1'b1;
      end
    end else begin
      esc_nxt = 1'b0;
      emit    = 1'b1;
      case (in_fmt_char)
        bfe_pkg::ChLowD: begin
          cmd.op = bfe_pkg::OP_SDEC;
          cmd.ch = in_value[7] ? bfe_pkg::ChMinus : bfe_pkg::ChSpace;
        end
        bfe_pkg::ChLowU: begin
          cmd.op = bfe_pkg::OP_UDEC;
        end
        bfe_pkg::ChLowB: begin
          cmd.op = bfe_pkg::OP_BIN;
          cmd.ch = in_value;
        end
        bfe_pkg::ChLowC: begin
          cmd.ch = in_value;
        end
        bfe_pkg::ChPercent: begin
          cmd.ch = bfe_pkg::ChPercent;
        end
        default: begin
          cmd.ch = bfe_pkg::ChBang;  // unknown conversion or end after percent
        end
      endcase
    end
  end

  assign push     = xfer && emit;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else if (xfer) begin
      esc_r <= esc_nxt;
    end
  end

endmodule

>>> design/bfe_queue.sv
module bfe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bfe_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output bfe_pkg::cmd_t      head,
  output bfe_pkg::q_status_t status
);

  bfe_pkg::cmd_t             mem [bfe_pkg::QDepth];
  logic [bfe_pkg::QPtrW-1:0] wr_ptr_r;
  logic [bfe_pkg::QPtrW-1:0] rd_ptr_r;
  logic [bfe_pkg::QPtrW:0]   count_r;
  logic [bfe_pkg::QPtrW:0]   count_nxt;

  assign status.full  = (count_r == (bfe_pkg::QPtrW+1)'(bfe_pkg::QDepth));
  assign status.empty = (count_r == '0);
  assign head         = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> design/bfe_back.sv
module bfe_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bfe_pkg::cmd_t             head,
  input  bfe_pkg::q_status_t        q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bfe_pkg::CharW-1:0] out_char,
  output logic                      out_last_of_run
);

  logic [bfe_pkg::RunIdxW-1:0] idx_r;
  logic [bfe_pkg::RunIdxW-1:0] last_idx;
  logic                        out_valid_r;
  logic [bfe_pkg::CharW-1:0]   out_char_r;
  logic                        out_last_r;
  logic [bfe_pkg::CharW-1:0]   char_sel;
  logic [bfe_pkg::DigitW-1:0]  digit;
  logic [bfe_pkg::RunIdxW-1:0] bit_pos;
  logic                        load;
  logic                        take;
  logic                        is_last;

  always_comb begin
    digit    = head.d0;
    bit_pos  = ~idx_r;  // 7 - idx
    char_sel = head.ch;
    last_idx = '0;
    case (head.op)
      bfe_pkg::OP_LIT: begin
        last_idx = 3'd0;
      end
      bfe_pkg::OP_SDEC: begin
        last_idx = 3'd3;
        case (idx_r)
          3'd1:    digit = head.d2;
          3'd2:    digit = head.d1;
          default: digit = head.d0;
        endcase
        char_sel = (idx_r == 3'd0) ? head.ch : (bfe_pkg::ChZero | {4'd0, digit});
      end
      bfe_pkg::OP_UDEC: begin
        last_idx = 3'd2;
        case (idx_r)
          3'd0:    digit = head.d2;
          3'd1:    digit = head.d1;
          default: digit = head.d0;
        endcase
        char_sel = bfe_pkg::ChZero | {4'd0, digit};
      end
      bfe_pkg::OP_BIN: begin
        last_idx = 3'd7;
        char_sel = head.ch[bit_pos] ? bfe_pkg::ChOne : bfe_pkg::ChZero;
      end
      default: begin
        last_idx = 3'd0;
      end
    endcase
  end

  assign load    = !out_valid_r || out_ready;
  assign take    = load && !q_status.empty;
  assign is_last = (idx_r == last_idx);
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (take) begin
      out_char_r <= char_sel;
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= !q_status.empty;
      end
      if (take) begin
        idx_r <= is_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

endmodule

>>> design/bfe_checker.sv
module bfe_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [bfe_pkg::CharW-1:0] in_fmt_char,
  input logic [bfe_pkg::CharW-1:0] in_value,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bfe_pkg::CharW-1:0] out_char,
  input logic                      out_last_of_run
);

  // characters transferred since the last end of run
  logic [3:0] run_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (out_valid && out_ready) begin
      run_cnt_r <= out_last_of_run ? 4'd0 : run_cnt_r + 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last_of_run))
    else $error("output changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> run_cnt_r < 4'd8)
    else $error("run longer than eight characters");

  a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with nothing to deliver");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_fmt_char) && $stable(in_value))
    else $error("input changed while waiting for transfer");

endmodule

bind byte_format_expander bfe_checker u_bfe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_fmt_char     (in_fmt_char),
  .in_value        (in_value),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_char        (out_char),
  .out_last_of_run (out_last_of_run)
);
